### src/tbp_pkg.sv
// shared types, register codes and a counter helper for the tournament predictor
package tbp_pkg;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_GLOBAL_HISTORY_BITS = 2'd0,
    REG_LOCAL_HISTORY_BITS  = 2'd1,
    REG_PC_INDEX_BITS       = 2'd2
  } cfg_reg_t;

  localparam logic [CFG_DATA_W-1:0] GLOBAL_HISTORY_BITS_RST = 4'd9;
  localparam logic [CFG_DATA_W-1:0] LOCAL_HISTORY_BITS_RST  = 4'd10;
  localparam logic [CFG_DATA_W-1:0] PC_INDEX_BITS_RST       = 4'd10;

  // 2-bit counter reset value: weakly not taken, weakly prefer global
  localparam logic [1:0] CTR_WEAK_LOW = 2'd1;

  typedef struct packed {
    logic [31:0] branch_pc;
    logic        taken;
  } in_t;

  typedef struct packed {
    logic predicted_taken;
    logic chose_local;
  } out_t;

  // saturating 2-bit counter step
  function automatic logic [1:0] ctr_bump(input logic [1:0] c, input logic up);
    logic [1:0] r;
    r = c;
    if (up) begin
      if (c != 2'd3) r = c + 2'd1;
    end else begin
      if (c != 2'd0) r = c - 2'd1;
    end
    return r;
  endfunction

endpackage

### src/tbp_ram.sv
// generic single-write, single-read synchronous ram with registered read
module tbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while re is low
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/tbp_len_mask.sv
// clamps a history length register and expands it to a low-bit mask
module tbp_len_mask #(
  parameter int MAX = 13
) (
  input  logic [tbp_pkg::CFG_DATA_W-1:0] len,
  output logic [MAX-1:0]                 mask
);

  localparam logic [4:0] LIMIT = 5'(MAX);

  logic [4:0] len_ext;
  logic [4:0] len_eff;

  assign len_ext = 5'(len);

  always_comb begin
    // zero acts as one, anything above the limit as the limit
    if (len_ext == 5'd0) begin
      len_eff = 5'd1;
    end else if (len_ext > LIMIT) begin
      len_eff = LIMIT;
    end else begin
      len_eff = len_ext;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX; i++) begin
      mask[i] = (5'(i) < len_eff);
    end
  end

endmodule

### src/tournament_branch_predictor_unit.sv
// top level of the tournament (local, global, chooser) branch predictor
//
//  channel | signals                          | moves
//  --------+----------------------------------+----------------------------------
//  in      | in_valid, in_ready, in_data      | resolved branch: pc and outcome
//  out     | out_valid, out_ready, out_data   | prediction and chooser selection
//  cfg     | cfg_we, cfg_index, cfg_data      | history and pc index lengths
//
//  each transaction runs in order: accept and read history table plus global/chooser
//    ram, read local counters with the masked local history, then compute and write back
//  the local counter read depends on the local history read, so the two run in sequence
//  after reset a clearing pass sweeps 2**max(GHIST_MAX, LHIST_MAX, PC_INDEX_MAX)
//    addresses (8192 with the defaults); in_ready stays low, cfg writes are taken
//  a stalled output holds the block in its last step until the result is taken; one
//    new transaction may be accepted while a result waits
module tournament_branch_predictor_unit #(
  parameter int GHIST_MAX    = 13,
  parameter int LHIST_MAX    = 11,
  parameter int PC_INDEX_MAX = 11
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  tbp_pkg::in_t                        in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output tbp_pkg::out_t                       out_data,
  input  logic                                cfg_we,
  input  logic [tbp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tbp_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int GDEPTH  = 1 << GHIST_MAX;
  localparam int LDEPTH  = 1 << LHIST_MAX;
  localparam int PDEPTH  = 1 << PC_INDEX_MAX;
  localparam int GL_MAX  = (GHIST_MAX > LHIST_MAX) ? GHIST_MAX : LHIST_MAX;
  localparam int CLR_BITS = (GL_MAX > PC_INDEX_MAX) ? GL_MAX : PC_INDEX_MAX;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_LHT   = 4'b0100,
    S_LC    = 4'b1000
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic [tbp_pkg::CFG_DATA_W-1:0] global_history_bits;
  logic [tbp_pkg::CFG_DATA_W-1:0] local_history_bits;
  logic [tbp_pkg::CFG_DATA_W-1:0] pc_index_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      global_history_bits <= tbp_pkg::GLOBAL_HISTORY_BITS_RST;
      local_history_bits  <= tbp_pkg::LOCAL_HISTORY_BITS_RST;
      pc_index_bits       <= tbp_pkg::PC_INDEX_BITS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tbp_pkg::REG_GLOBAL_HISTORY_BITS: global_history_bits <= cfg_data;
        tbp_pkg::REG_LOCAL_HISTORY_BITS:  local_history_bits  <= cfg_data;
        tbp_pkg::REG_PC_INDEX_BITS:       pc_index_bits       <= cfg_data;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // length masks
  logic [GHIST_MAX-1:0]    gmask;
  logic [LHIST_MAX-1:0]    lmask;
  logic [PC_INDEX_MAX-1:0] pmask;

  tbp_len_mask #(.MAX(GHIST_MAX)) u_gmask (.len(global_history_bits), .mask(gmask));
  tbp_len_mask #(.MAX(LHIST_MAX)) u_lmask (.len(local_history_bits), .mask(lmask));
  tbp_len_mask #(.MAX(PC_INDEX_MAX)) u_pmask (.len(pc_index_bits), .mask(pmask));

  // control registers
  logic [CLR_BITS-1:0]     clr_cnt;
  logic [GHIST_MAX-1:0]    global_history;

  // transaction registers (payload, no reset)
  logic [PC_INDEX_MAX-1:0] pi;
  logic [GHIST_MAX-1:0]    gi;
  logic [LHIST_MAX-1:0]    li;
  logic                    taken;

  // ram ports
  logic                    lht_we, lht_re;
  logic [PC_INDEX_MAX-1:0] lht_waddr;
  logic [LHIST_MAX-1:0]    lht_wdata, lht_rdata;
  logic                    lc_we, lc_re;
  logic [LHIST_MAX-1:0]    lc_waddr, lc_raddr;
  logic [1:0]              lc_wdata, lc_rdata;
  logic                    gch_we, gch_re;
  logic [GHIST_MAX-1:0]    gch_waddr;
  logic [3:0]              gch_wdata, gch_rdata;   // {global counter, chooser}

  logic accept;
  logic finish;
  logic clr_done;

  logic [GHIST_MAX-1:0]    gi_now;
  logic [PC_INDEX_MAX-1:0] pi_now;
  logic [LHIST_MAX-1:0]    li_now;

  logic gpred, lpred, use_local;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  // last step waits for the output register to be free
  assign finish   = (state == S_LC) && (!out_valid || out_ready);
  assign clr_done = (clr_cnt == {CLR_BITS{1'b1}});

  assign gi_now = global_history & gmask;
  assign pi_now = in_data.branch_pc[PC_INDEX_MAX-1:0] & pmask;
  assign li_now = lht_rdata & lmask;

  assign gpred     = gch_rdata[3];
  assign use_local = gch_rdata[1];
  assign lpred     = lc_rdata[1];

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_done) state_next = S_IDLE;
      S_IDLE:  if (accept) state_next = S_LHT;
      S_LHT:   state_next = S_LC;
      S_LC:    if (finish) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_cnt        <= '0;
      global_history <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (finish) begin
        global_history <= GHIST_MAX'({gi, taken}) & gmask;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pi    <= pi_now;
      gi    <= gi_now;
      taken <= in_data.taken;
    end
    if (state == S_LHT) begin
      li <= li_now;
    end
    if (finish) begin
      out_data.predicted_taken <= use_local ? lpred : gpred;
      out_data.chose_local     <= use_local;
    end
  end

  // ram control: clearing sweep, or the read-modify-write of one transaction
  always_comb begin
    lht_re    = accept;
    gch_re    = accept;
    lc_re     = (state == S_LHT);
    lc_raddr  = li_now;

    lht_we    = 1'b0;
    lht_waddr = pi;
    lht_wdata = LHIST_MAX'({li_now, taken}) & lmask;
    lc_we     = 1'b0;
    lc_waddr  = li;
    lc_wdata  = tbp_pkg::ctr_bump(lc_rdata, taken);
    gch_we    = 1'b0;
    gch_waddr = gi;
    gch_wdata[3:2] = tbp_pkg::ctr_bump(gch_rdata[3:2], taken);
    // chooser moves only when the two sides disagree
    gch_wdata[1:0] = (gpred != lpred) ? tbp_pkg::ctr_bump(gch_rdata[1:0], lpred == taken)
                                      : gch_rdata[1:0];

    case (state)
      S_CLEAR: begin
        lht_we    = 1'b1;
        lht_waddr = clr_cnt[PC_INDEX_MAX-1:0];
        lht_wdata = '0;
        lc_we     = 1'b1;
        lc_waddr  = clr_cnt[LHIST_MAX-1:0];
        lc_wdata  = tbp_pkg::CTR_WEAK_LOW;
        gch_we    = 1'b1;
        gch_waddr = clr_cnt[GHIST_MAX-1:0];
        gch_wdata = {tbp_pkg::CTR_WEAK_LOW, tbp_pkg::CTR_WEAK_LOW};
      end
      S_LHT: begin
        lht_we = 1'b1;
      end
      S_LC: begin
        lc_we  = finish;
        gch_we = finish;
      end
      default: ;
    endcase
  end

  // per-pc local history table
  tbp_ram #(.WIDTH(LHIST_MAX), .DEPTH(PDEPTH)) u_lht (
    .clk   (clk),
    .we    (lht_we),
    .waddr (lht_waddr),
    .wdata (lht_wdata),
    .re    (lht_re),
    .raddr (pi_now),
    .rdata (lht_rdata)
  );

  // local counters
  tbp_ram #(.WIDTH(2), .DEPTH(LDEPTH)) u_lc (
    .clk   (clk),
    .we    (lc_we),
    .waddr (lc_waddr),
    .wdata (lc_wdata),
    .re    (lc_re),
    .raddr (lc_raddr),
    .rdata (lc_rdata)
  );

  // global counters and chooser share the global history index
  tbp_ram #(.WIDTH(4), .DEPTH(GDEPTH)) u_gch (
    .clk   (clk),
    .we    (gch_we),
    .waddr (gch_waddr),
    .wdata (gch_wdata),
    .re    (gch_re),
    .raddr (gi_now),
    .rdata (gch_rdata)
  );

endmodule
